// ===== design/ccdt_pkg.sv =====
// ccdt_pkg: shared widths, action and status codes and defaults of the command
// code dispatch table. Depends on nothing; used by the interfaces and the top level.
`default_nettype none

package ccdt_pkg;

   localparam int ACTION_BITS  = 2;
   localparam int CODE_BITS    = 32;
   localparam int HANDLER_PORT = 8;
   localparam int STATUS_BITS  = 2;
   localparam int SLOT_BITS    = 4;

   localparam int DEF_TABLE_DEPTH  = 16;
   localparam int DEF_HANDLER_BITS = 8;

   localparam logic [ACTION_BITS-1:0] ACT_REGISTER   = 2'd0;
   localparam logic [ACTION_BITS-1:0] ACT_UNREGISTER = 2'd1;
   localparam logic [ACTION_BITS-1:0] ACT_LOOKUP     = 2'd2;

   localparam logic [STATUS_BITS-1:0] STAT_OK        = 2'd0;
   localparam logic [STATUS_BITS-1:0] STAT_FULL      = 2'd1;
   localparam logic [STATUS_BITS-1:0] STAT_NOT_FOUND = 2'd2;

endpackage

`default_nettype wire

// ===== design/ccdt_if.sv =====
// ccdt_req_if and ccdt_rsp_if: valid/ready channels of the dispatch table.
// Depends on ccdt_pkg for the payload widths.
`default_nettype none

interface ccdt_req_if
   import ccdt_pkg::*;
   ();
   logic                    valid;
   logic                    ready;
   logic [ACTION_BITS-1:0]  action;
   logic [CODE_BITS-1:0]    code;
   logic [HANDLER_PORT-1:0] handler_in;

   modport source (output valid, action, code, handler_in, input ready);
   modport sink   (input valid, action, code, handler_in, output ready);
endinterface

interface ccdt_rsp_if
   import ccdt_pkg::*;
   ();
   logic                    valid;
   logic                    ready;
   logic [STATUS_BITS-1:0]  status;
   logic [SLOT_BITS-1:0]    slot;
   logic [HANDLER_PORT-1:0] handler_out;

   modport source (output valid, status, slot, handler_out, input ready);
   modport sink   (input valid, status, slot, handler_out, output ready);
endinterface

`default_nettype wire

// ===== design/command_code_dispatch_table.sv =====
// command_code_dispatch_table: a beat scans the slots in order from slot 0, one read per slot;
// the RAM read is registered, so a slot is compared after its read, and the scan ends at the first
// hit or at the last slot; the write-back and the result register load follow. A reserved action
// skips the scan. A new beat is taken only in idle, once the result is loaded, not during a scan;
// a beat is taken while a result still waits, and a waiting result holds the write-back cycle.
// Reset (synchronous) frees every slot through the used bits; the RAM is not cleared.
// Depends on ccdt_pkg, ccdt_if and ccdt_ram.
`default_nettype none

module command_code_dispatch_table
   import ccdt_pkg::*;
#(
   parameter int TABLE_DEPTH  = DEF_TABLE_DEPTH,
   parameter int HANDLER_BITS = DEF_HANDLER_BITS
) (
   input  wire logic    clock,
   input  wire logic    reset,
   ccdt_req_if.sink     req_ch,
   ccdt_rsp_if.source   rsp_ch
);

   localparam int IDX_W     = $clog2(TABLE_DEPTH);
   localparam int ENTRY_W   = CODE_BITS + HANDLER_BITS;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

   state_type                state_ff, state_in;
   logic [ACTION_BITS-1:0]   action_ff, action_in;
   logic [CODE_BITS-1:0]     code_ff, code_in;
   logic [HANDLER_BITS-1:0]  hdl_ff, hdl_in;
   logic [IDX_W-1:0]         rd_idx_ff, rd_idx_in;
   logic [IDX_W-1:0]         cmp_idx_ff, cmp_idx_in;
   logic                     cmp_vld_ff, cmp_vld_in;
   logic                     issued_all_ff, issued_all_in;
   logic [IDX_W-1:0]         hit_slot_ff, hit_slot_in;
   logic [HANDLER_BITS-1:0]  hit_hdl_ff, hit_hdl_in;
   logic                     found_ff, found_in;
   logic [TABLE_DEPTH-1:0]   used_ff, used_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [STATUS_BITS-1:0]   rsp_status_ff, rsp_status_in;
   logic [SLOT_BITS-1:0]     rsp_slot_ff, rsp_slot_in;
   logic [HANDLER_PORT-1:0]  rsp_hdl_ff, rsp_hdl_in;

   logic                     req_take;
   logic                     can_finish;
   logic                     ram_rd_en;
   logic                     ram_wr_en;
   logic [ENTRY_W-1:0]       ram_wr_data;
   logic [ENTRY_W-1:0]       ram_rd_data;
   logic [CODE_BITS-1:0]     rd_code;
   logic [HANDLER_BITS-1:0]  rd_hdl;
   logic                     cmp_used;
   logic                     hit;
   logic [HANDLER_BITS+HANDLER_PORT-1:0] hdl_wide_in;
   logic [HANDLER_BITS+HANDLER_PORT-1:0] hdl_wide_out;
   logic [IDX_W+SLOT_BITS-1:0]           slot_wide;

   ccdt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (hit_slot_ff),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (rd_idx_ff),
      .rd_data (ram_rd_data)
   );

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_take     = req_ch.valid && req_ch.ready;
   assign can_finish   = !rsp_valid_ff || rsp_ch.ready;

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.status      = rsp_status_ff;
   assign rsp_ch.slot        = rsp_slot_ff;
   assign rsp_ch.handler_out = rsp_hdl_ff;

   assign rd_code  = ram_rd_data[ENTRY_W-1:HANDLER_BITS];
   assign rd_hdl   = ram_rd_data[HANDLER_BITS-1:0];
   assign cmp_used = used_ff[cmp_idx_ff];

   // register looks for a free slot, the others for a used slot with the code
   assign hit = cmp_vld_ff &&
                ((action_ff == ACT_REGISTER) ? !cmp_used : (cmp_used && rd_code == code_ff));

   assign ram_rd_en = (state_ff == ST_SCAN) && !issued_all_ff;

   assign hdl_wide_in  = {{HANDLER_BITS{1'b0}}, req_ch.handler_in};
   assign hdl_wide_out = {{HANDLER_PORT{1'b0}}, hit_hdl_ff};
   assign slot_wide    = {{SLOT_BITS{1'b0}}, hit_slot_ff};

   always_comb begin
      state_in      = state_ff;
      action_in     = action_ff;
      code_in       = code_ff;
      hdl_in        = hdl_ff;
      rd_idx_in     = rd_idx_ff;
      cmp_idx_in    = cmp_idx_ff;
      cmp_vld_in    = 1'b0;
      issued_all_in = issued_all_ff;
      hit_slot_in   = hit_slot_ff;
      hit_hdl_in    = hit_hdl_ff;
      found_in      = found_ff;
      used_in       = used_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_hdl_in    = rsp_hdl_ff;
      ram_wr_en     = 1'b0;
      ram_wr_data   = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               action_in     = req_ch.action;
               code_in       = req_ch.code;
               hdl_in        = hdl_wide_in[HANDLER_BITS-1:0];
               rd_idx_in     = '0;
               issued_all_in = 1'b0;
               found_in      = 1'b0;
               hit_slot_in   = '0;
               // reserved action needs no scan
               if (req_ch.action inside {ACT_REGISTER, ACT_UNREGISTER, ACT_LOOKUP}) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_SCAN: begin
            if (hit) begin
               found_in    = 1'b1;
               hit_slot_in = cmp_idx_ff;
               hit_hdl_in  = rd_hdl;
               state_in    = ST_FINISH;
            end else if (cmp_vld_ff && cmp_idx_ff == LAST_IDX) begin
               state_in = ST_FINISH;
            end else if (!issued_all_ff) begin
               cmp_vld_in = 1'b1;
               cmp_idx_in = rd_idx_ff;
               rd_idx_in  = rd_idx_ff + 1'b1;
               if (rd_idx_ff == LAST_IDX) begin
                  issued_all_in = 1'b1;
               end
            end
         end
         ST_FINISH: begin
            if (can_finish) begin
               rsp_valid_in  = 1'b1;
               rsp_slot_in   = '0;
               rsp_hdl_in    = '0;
               if (found_ff) begin
                  rsp_status_in = STAT_OK;
                  rsp_slot_in   = slot_wide[SLOT_BITS-1:0];
                  case (action_ff)
                     ACT_REGISTER: begin
                        used_in[hit_slot_ff] = 1'b1;
                        ram_wr_en            = 1'b1;
                        ram_wr_data          = {code_ff, hdl_ff};
                     end
                     ACT_UNREGISTER: begin
                        // freed slot returns to zero
                        used_in[hit_slot_ff] = 1'b0;
                        ram_wr_en            = 1'b1;
                        ram_wr_data          = '0;
                     end
                     ACT_LOOKUP: begin
                        rsp_hdl_in = hdl_wide_out[HANDLER_PORT-1:0];
                     end
                     default: begin
                        rsp_status_in = STAT_NOT_FOUND;
                     end
                  endcase
               end else if (action_ff == ACT_REGISTER) begin
                  rsp_status_in = STAT_FULL;
               end else begin
                  rsp_status_in = STAT_NOT_FOUND;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         used_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
         cmp_vld_ff    <= 1'b0;
         issued_all_ff <= 1'b0;
         found_ff      <= 1'b0;
      end else begin
         state_ff      <= state_in;
         used_ff       <= used_in;
         rsp_valid_ff  <= rsp_valid_in;
         cmp_vld_ff    <= cmp_vld_in;
         issued_all_ff <= issued_all_in;
         found_ff      <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff     <= action_in;
      code_ff       <= code_in;
      hdl_ff        <= hdl_in;
      rd_idx_ff     <= rd_idx_in;
      cmp_idx_ff    <= cmp_idx_in;
      hit_slot_ff   <= hit_slot_in;
      hit_hdl_ff    <= hit_hdl_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_hdl_ff    <= rsp_hdl_in;
   end

endmodule

`default_nettype wire

// ===== design/ccdt_ram.sv =====
// ccdt_ram: generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`default_nettype none

module ccdt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== dv/command_code_dispatch_table_tb.sv =====
// command_code_dispatch_table_tb: self-checking bench for the command code dispatch table.
// Drives commands, predicts each reply from a local copy of the table, checks replies in order.
// Depends on ccdt_pkg, ccdt_req_if/ccdt_rsp_if and command_code_dispatch_table.
`timescale 1ns / 1ps

module command_code_dispatch_table_tb;
   import ccdt_pkg::*;

   localparam int DEPTH = DEF_TABLE_DEPTH;
   localparam logic [ACTION_BITS-1:0]  ACT_RESERVED = 2'd3;
   localparam logic [HANDLER_PORT-1:0] HANDLER_MASK = HANDLER_PORT'((1 << DEF_HANDLER_BITS) - 1);
   localparam int TAIL_CYCLES = DEPTH + 8;
   localparam int MAX_PRINTS  = 100;

   typedef struct packed {
      logic [STATUS_BITS-1:0]  status;
      logic [SLOT_BITS-1:0]    slot;
      logic [HANDLER_PORT-1:0] handler;
   } reply_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ccdt_req_if req_ch ();
   ccdt_rsp_if rsp_ch ();

   command_code_dispatch_table u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // local copy of the table
   logic                    tbl_used    [DEPTH];
   logic [CODE_BITS-1:0]    tbl_code    [DEPTH];
   logic [HANDLER_PORT-1:0] tbl_handler [DEPTH];

   reply_type pending_replies[$];
   int     error_count  = 0;
   bit     req_idle_en  = 1'b1;
   bit     rsp_stall_en = 1'b1;
   int     rsp_hold_len = 0;
   logic [CODE_BITS-1:0] code_pool[20];

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   task automatic report_mismatch(input string what);
      error_count++;
      if (error_count <= MAX_PRINTS)
         $display("mismatch at %0t ns: %s", $time, what);
   endtask

   // applies one command to the local table and returns the reply it should give
   function automatic reply_type apply_command(input logic [ACTION_BITS-1:0] action,
                                               input logic [CODE_BITS-1:0] code,
                                               input logic [HANDLER_PORT-1:0] handler);
      reply_type r;
      int        hit;
      r.status  = STAT_NOT_FOUND;
      r.slot    = '0;
      r.handler = '0;
      hit = -1;
      if (action == ACT_REGISTER) begin
         for (int i = DEPTH - 1; i >= 0; i--)
            if (!tbl_used[i]) hit = i;
         if (hit < 0) begin
            r.status = STAT_FULL;
         end else begin
            tbl_used[hit]    = 1'b1;
            tbl_code[hit]    = code;
            tbl_handler[hit] = handler & HANDLER_MASK;
            r.status = STAT_OK;
            r.slot   = hit[SLOT_BITS-1:0];
         end
      end else if (action == ACT_UNREGISTER || action == ACT_LOOKUP) begin
         for (int i = DEPTH - 1; i >= 0; i--)
            if (tbl_used[i] && tbl_code[i] == code) hit = i;
         if (hit >= 0) begin
            r.status = STAT_OK;
            r.slot   = hit[SLOT_BITS-1:0];
            if (action == ACT_LOOKUP) begin
               r.handler = tbl_handler[hit];
            end else begin
               tbl_used[hit]    = 1'b0;
               tbl_code[hit]    = '0;
               tbl_handler[hit] = '0;
            end
         end
      end
      return r;
   endfunction

   // one command beat; valid stays high afterwards unless the next call idles first
   task automatic send_cmd(input logic [ACTION_BITS-1:0] action,
                           input logic [CODE_BITS-1:0] code,
                           input logic [HANDLER_PORT-1:0] handler);
      if (req_idle_en && $urandom_range(0, 5) == 0) begin
         @(negedge clock);
         req_ch.valid = 1'b0;
         repeat ($urandom_range(1, 12) - 1) @(negedge clock);
      end
      @(negedge clock);
      req_ch.valid      = 1'b1;
      req_ch.action     = action;
      req_ch.code       = code;
      req_ch.handler_in = handler;
      do @(posedge clock); while (!req_ch.ready);
      pending_replies.push_back(apply_command(action, code, handler));
   endtask

   // valid drops before the block is ready again, so the last beat is not taken twice
   task automatic wait_drained();
      @(negedge clock);
      req_ch.valid = 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
   endtask

   // receiver: random stall bursts, plus a long hold-off on request
   initial begin
      rsp_ch.ready = 1'b1;
      forever begin
         @(negedge clock);
         if (rsp_hold_len > 0) begin
            rsp_ch.ready = 1'b0;
            repeat (rsp_hold_len) @(negedge clock);
            rsp_hold_len = 0;
         end else if (rsp_stall_en && $urandom_range(0, 7) == 0) begin
            rsp_ch.ready = 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clock);
         end
         rsp_ch.ready = 1'b1;
      end
   end

   always @(posedge clock) begin
      reply_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_replies.size() == 0) begin
            report_mismatch("reply beat with no command outstanding");
         end else begin
            want = pending_replies.pop_front();
            if (rsp_ch.status !== want.status)
               report_mismatch($sformatf("status got %0d want %0d", rsp_ch.status, want.status));
            if (rsp_ch.slot !== want.slot)
               report_mismatch($sformatf("slot got %0d want %0d", rsp_ch.slot, want.slot));
            if (rsp_ch.handler_out !== want.handler)
               report_mismatch($sformatf("handler got %0d want %0d",
                                         rsp_ch.handler_out, want.handler));
         end
      end
   end

   task automatic test_directed();
      send_cmd(ACT_LOOKUP, 32'h0000_0000, 8'hFF);       // empty table
      send_cmd(ACT_UNREGISTER, 32'h1234_5678, 8'h00);   // absent code
      send_cmd(ACT_REGISTER, 32'h0000_0000, 8'h00);
      send_cmd(ACT_REGISTER, 32'hFFFF_FFFF, 8'hFF);
      send_cmd(ACT_REGISTER, 32'hFFFF_FFFF, 8'h5A);     // duplicate, shadowed
      send_cmd(ACT_LOOKUP, 32'hFFFF_FFFF, 8'h00);
      send_cmd(ACT_LOOKUP, 32'h0000_0000, 8'hFF);
      send_cmd(ACT_RESERVED, 32'hFFFF_FFFF, 8'hFF);
      send_cmd(ACT_UNREGISTER, 32'hFFFF_FFFF, 8'hFF);
      send_cmd(ACT_LOOKUP, 32'hFFFF_FFFF, 8'h00);       // now the shadowed copy
      send_cmd(ACT_REGISTER, 32'hA5A5_A5A5, 8'h01);     // reuses the freed slot
      send_cmd(ACT_LOOKUP, 32'h0000_0001, 8'h00);
      send_cmd(ACT_UNREGISTER, 32'h0000_0000, 8'h00);
      send_cmd(ACT_UNREGISTER, 32'hFFFF_FFFF, 8'h00);
      send_cmd(ACT_UNREGISTER, 32'hA5A5_A5A5, 8'h00);
      send_cmd(ACT_LOOKUP, 32'hA5A5_A5A5, 8'h00);
   endtask

   task automatic test_table_full();
      for (int i = 0; i <= DEPTH; i++)
         send_cmd(ACT_REGISTER, 32'h0000_0100 + i, 8'(i + 1));
      send_cmd(ACT_LOOKUP, 32'h0000_0100 + DEPTH, 8'h00);   // its register was refused when full, so not found
      send_cmd(ACT_LOOKUP, 32'h0000_0100 + DEPTH - 1, 8'h00);
      send_cmd(ACT_UNREGISTER, 32'h0000_0105, 8'h00);
      send_cmd(ACT_REGISTER, 32'h8000_0000, 8'h80);
      send_cmd(ACT_REGISTER, 32'h8000_0001, 8'h81);
   endtask

   // reply side held off long enough for the block to stall its input
   task automatic test_backpressure();
      rsp_hold_len = 80;
      for (int i = 0; i < 10; i++)
         send_cmd(ACT_LOOKUP, code_pool[$urandom_range(0, 19)], 8'($urandom));
      wait_drained();
   endtask

   task automatic test_random_traffic(input int count, input bit idle);
      int target;
      int occupied;
      int roll;
      logic [ACTION_BITS-1:0] action;
      logic [CODE_BITS-1:0]   code;
      req_idle_en  = idle;
      rsp_stall_en = idle;
      target = DEPTH / 2;
      for (int n = 0; n < count; n++) begin
         if (n % 40 == 0) target = $urandom_range(0, DEPTH);
         occupied = 0;
         for (int i = 0; i < DEPTH; i++) occupied += tbl_used[i];
         roll = $urandom_range(0, 99);
         if ($urandom_range(0, 6) == 0) code = $urandom();
         else                           code = code_pool[$urandom_range(0, 19)];
         if (roll < 4)
            action = ACT_RESERVED;
         else if (roll < 40)
            action = ACT_LOOKUP;
         else if (occupied < target || (target == DEPTH && roll < 60))
            action = ACT_REGISTER;   // pushing past full now and then
         else
            action = ACT_UNREGISTER;
         send_cmd(action, code, 8'($urandom));
      end
   endtask

   initial begin
      for (int i = 0; i < DEPTH; i++) begin
         tbl_used[i]    = 1'b0;
         tbl_code[i]    = '0;
         tbl_handler[i] = '0;
      end
      foreach (code_pool[i]) code_pool[i] = $urandom();
      code_pool[0] = 32'h0000_0000;
      code_pool[1] = 32'hFFFF_FFFF;
      code_pool[2] = 32'h8000_0000;
      req_ch.valid      = 1'b0;
      req_ch.action     = ACT_REGISTER;
      req_ch.code       = '0;
      req_ch.handler_in = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_table_full();
      test_backpressure();
      test_random_traffic(520, 1'b1);
      wait_drained();              // sender pauses until the table has answered everything
      test_random_traffic(180, 1'b0);
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);

      if (error_count == 0)
         $display("command_code_dispatch_table regression: pass");
      else
         $display("command_code_dispatch_table regression: fail");
      $finish;
   end

   initial begin
      #1_000_000;
      $display("timeout with %0d replies outstanding", pending_replies.size());
      $display("command_code_dispatch_table regression: fail");
      $finish;
   end

endmodule

// ===== command_code_dispatch_table.f =====
design/ccdt_pkg.sv
design/ccdt_if.sv
design/ccdt_ram.sv
design/command_code_dispatch_table.sv
dv/command_code_dispatch_table_tb.sv
